// ===== hdl/sau_pkg.sv =====
`default_nettype none

package sau_pkg;

    // operation codes of a command word
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_REM  = 3'd4;

    // status codes of a response word
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_SHORT   = 2'd1;
    localparam logic [1:0] STATUS_DIVZERO = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;

    // main sequencer
    typedef enum logic [1:0] {
        STATE_IDLE,
        STATE_EXEC,
        STATE_CALC,
        STATE_DONE
    } sau_state_t;

    // shared unit phases
    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_RUN,
        ALU_FIX,
        ALU_DONE
    } alu_phase_t;

    typedef enum logic [1:0] {
        FN_MUL,
        FN_DIV,
        FN_REM
    } alu_fn_t;

    typedef struct packed {
        logic    start;
        alu_fn_t fn;
    } sau_alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } sau_alu_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/sau_if.sv =====
`default_nettype none

// command channel
interface sau_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

// response channel
interface sau_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [6:0]         entry_count;

    modport source (output valid, output status, output top_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input top_value, input entry_count,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/sau_alu.sv =====
`default_nettype none

module sau_alu
    import sau_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sau_alu_req_t       req,
    input  wire logic [DATA_W-1:0]  opa,
    input  wire logic [DATA_W-1:0]  opb,
    output sau_alu_rsp_t            rsp
);

    localparam int unsigned STEP_W = $clog2(DATA_W);

    alu_phase_t          phase_reg, phase_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    alu_fn_t             fn_reg, fn_next;
    logic                neg_reg, neg_next;
    logic [DATA_W:0]     acc_reg, acc_next;
    logic [DATA_W-1:0]   x_reg, x_next;
    logic [DATA_W-1:0]   y_reg, y_next;
    logic [DATA_W-1:0]   res_reg, res_next;

    logic [DATA_W:0]     add_x;
    logic [DATA_W:0]     add_y;
    logic                add_sub;
    logic [DATA_W:0]     add_res;
    logic [DATA_W:0]     rem_shift;
    logic [DATA_W-1:0]   fix_val;

    // shared adder, subtracts when add_sub is set
    assign add_res = add_x + (add_sub ? ~add_y : add_y) + {{DATA_W{1'b0}}, add_sub};

    assign rem_shift = {acc_reg[DATA_W-1:0], x_reg[DATA_W-1]};
    assign fix_val   = (fn_reg == FN_MUL) ? acc_reg[DATA_W-1:0] :
                       (fn_reg == FN_REM) ? acc_reg[DATA_W-1:0] : x_reg;

    // adder operand selection
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (phase_reg)
            ALU_RUN:
            begin
                if (fn_reg == FN_MUL)
                begin
                    add_x = {1'b0, acc_reg[DATA_W-1:0]};
                    add_y = {1'b0, (y_reg[0] ? x_reg : '0)};
                end
                else
                begin
                    add_x   = rem_shift;
                    add_y   = {1'b0, y_reg};
                    add_sub = 1'b1;
                end
            end
            ALU_FIX:
            begin
                add_y   = {1'b0, fix_val};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            ALU_IDLE: if (req.start) phase_next = ALU_RUN;
            ALU_RUN:  if (step_reg == STEP_W'(DATA_W - 1)) phase_next = ALU_FIX;
            ALU_FIX:  phase_next = ALU_DONE;
            ALU_DONE: phase_next = ALU_IDLE;
            default:  phase_next = ALU_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        step_next = step_reg;
        fn_next   = fn_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        res_next  = res_reg;
        case (phase_reg)
            ALU_IDLE:
            begin
                if (req.start)
                begin
                    step_next = '0;
                    fn_next   = req.fn;
                    acc_next  = '0;
                    case (req.fn)
                        FN_MUL:
                        begin
                            neg_next = 1'b0;
                            x_next   = opa;
                            y_next   = opb;
                        end
                        FN_DIV:
                        begin
                            neg_next = opa[DATA_W-1] ^ opb[DATA_W-1];
                            x_next   = opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
                            y_next   = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;
                        end
                        default:
                        begin
                            neg_next = opa[DATA_W-1];
                            x_next   = opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
                            y_next   = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;
                        end
                    endcase
                end
            end
            ALU_RUN:
            begin
                step_next = step_reg + STEP_W'(1);
                if (fn_reg == FN_MUL)
                begin
                    // shift-add, one multiplier bit per cycle
                    acc_next = {1'b0, add_res[DATA_W-1:0]};
                    x_next   = {x_reg[DATA_W-2:0], 1'b0};
                    y_next   = {1'b0, y_reg[DATA_W-1:1]};
                end
                else
                begin
                    // restoring division, one quotient bit per cycle
                    if (add_res[DATA_W])
                    begin
                        acc_next = rem_shift;
                        x_next   = {x_reg[DATA_W-2:0], 1'b0};
                    end
                    else
                    begin
                        acc_next = add_res;
                        x_next   = {x_reg[DATA_W-2:0], 1'b1};
                    end
                end
            end
            ALU_FIX:
            begin
                // sign correction through the same adder
                res_next = neg_reg ? add_res[DATA_W-1:0] : fix_val;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ALU_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        fn_reg   <= fn_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        res_reg  <= res_next;
    end

    assign rsp.done   = (phase_reg == ALU_DONE);
    assign rsp.result = res_reg;

endmodule

`default_nettype wire

// ===== hdl/stack_arithmetic_unit_core.sv =====
`default_nettype none

// stack arithmetic unit: bounded stack of 32-bit signed integers
// cmd channel takes one word: an operation code and a value to push
// (push, subtract, multiply, divide, remainder); rsp channel gives one word
// per command: status, new top of stack (0 when empty) and entry count
// push, subtract, errors, unused codes: idle (accept), execute, done; done
// loads the response register once free, then the next command is taken
// multiply, divide, remainder: calc between execute and done, with the shared
// shift-add / restoring-divide unit at one bit per cycle
// the top entry sits in a register, the rest in a single-port memory whose
// second entry is read when the command is accepted
// reset empties the stack at once; no clearing pass is needed
// the response sits in an output register; a command is accepted while it
// waits, but the next response is held back until the receiver takes it
// errors (too few entries, zero divisor, full stack) leave the stack as is

module stack_arithmetic_unit_core
    import sau_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sau_cmd_if.sink    cmd,
    sau_rsp_if.source  rsp
);

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);

    sau_state_t          state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [DATA_W-1:0]   pv_reg, pv_next;
    logic [DATA_W-1:0]   rd_reg;
    logic [DATA_W-1:0]   top_reg, top_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [DATA_W-1:0]   result_reg, result_next;
    logic [1:0]          status_reg, status_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [1:0]          rsp_status_reg, rsp_status_next;
    logic [DATA_W-1:0]   rsp_top_reg, rsp_top_next;
    logic [COUNT_W-1:0]  rsp_count_reg, rsp_count_next;

    logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;

    sau_alu_req_t        alu_req;
    sau_alu_rsp_t        alu_rsp;

    logic                accept;
    logic                out_free;
    logic                is_arith;
    logic                is_long;
    logic                too_short;
    logic                div_zero;
    logic                commit;

    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign is_arith  = (op_reg == OP_SUB) || (op_reg == OP_MUL) ||
                       (op_reg == OP_DIV) || (op_reg == OP_REM);
    assign is_long   = (op_reg == OP_MUL) || (op_reg == OP_DIV) || (op_reg == OP_REM);
    assign too_short = (count_reg < CW'(2));
    assign div_zero  = ((op_reg == OP_DIV) || (op_reg == OP_REM)) && (top_reg == '0);
    assign commit    = (state_reg == STATE_DONE) && out_free;

    assign wr_addr = AW'(count_reg - CW'(1));
    assign rd_addr = AW'(count_reg - CW'(2));
    assign mem_re  = accept;
    assign mem_we  = commit && (op_reg == OP_PUSH) && (status_reg == STATUS_OK) &&
                     (count_reg != '0);

    // shared multiply / divide unit
    sau_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .opa   (rd_reg),
        .opb   (top_reg),
        .rsp   (alu_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            STATE_IDLE: if (cmd.valid) state_next = STATE_EXEC;
            STATE_EXEC:
            begin
                if (is_long && !too_short && !div_zero)
                    state_next = STATE_CALC;
                else
                    state_next = STATE_DONE;
            end
            STATE_CALC: if (alu_rsp.done) state_next = STATE_DONE;
            STATE_DONE: if (out_free) state_next = STATE_IDLE;
            default:    state_next = STATE_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        op_next         = op_reg;
        pv_next         = pv_reg;
        top_next        = top_reg;
        count_next      = count_reg;
        result_next     = result_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_top_next    = rsp_top_reg;
        rsp_count_next  = rsp_count_reg;
        alu_req.start   = 1'b0;
        alu_req.fn      = FN_MUL;
        cmd.ready       = (state_reg == STATE_IDLE);

        case (op_reg)
            OP_DIV:  alu_req.fn = FN_DIV;
            OP_REM:  alu_req.fn = FN_REM;
            default: alu_req.fn = FN_MUL;
        endcase

        case (state_reg)
            STATE_IDLE:
            begin
                if (accept)
                begin
                    op_next = cmd.operation;
                    pv_next = cmd.push_value;
                end
            end
            STATE_EXEC:
            begin
                // checks in order: short stack before zero divisor
                status_next = STATUS_OK;
                result_next = rd_reg - top_reg;
                if (op_reg == OP_PUSH)
                begin
                    if (count_reg == CW'(STACK_DEPTH))
                        status_next = STATUS_FULL;
                end
                else if (is_arith)
                begin
                    if (too_short)
                        status_next = STATUS_SHORT;
                    else if (div_zero)
                        status_next = STATUS_DIVZERO;
                    else if (is_long)
                        alu_req.start = 1'b1;
                end
            end
            STATE_CALC:
            begin
                if (alu_rsp.done)
                    result_next = alu_rsp.result;
            end
            STATE_DONE:
            begin
                // apply to the stack and load the response register
                if (out_free)
                begin
                    if (status_reg == STATUS_OK)
                    begin
                        if (op_reg == OP_PUSH)
                        begin
                            top_next   = pv_reg;
                            count_next = count_reg + CW'(1);
                        end
                        else if (is_arith)
                        begin
                            top_next   = result_reg;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_top_next    = (count_next == '0) ? '0 : top_next;
                    rsp_count_next  = COUNT_W'(count_next);
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pv_reg         <= pv_next;
        top_reg        <= top_next;
        result_reg     <= result_next;
        status_reg     <= status_next;
        rsp_status_reg <= rsp_status_next;
        rsp_top_reg    <= rsp_top_next;
        rsp_count_reg  <= rsp_count_next;
    end

    // entries below the top, single port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[wr_addr] <= top_reg;
        if (mem_re)
            rd_reg <= stack_mem[rd_addr];
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.top_value   = rsp_top_reg;
    assign rsp.entry_count = rsp_count_reg;

endmodule

`default_nettype wire
